// File: design/extent_map_translate_append_core_macros.svh
// ----------------------------------------------------------------------------
// extent map assertion macros
// concurrent check wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef EXTENT_MAP_TRANSLATE_APPEND_CORE_MACROS_SVH
`define EXTENT_MAP_TRANSLATE_APPEND_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define EMTA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// antecedent implies consequent in the next cycle
`define EMTA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define EMTA_ASSERT(lbl, clk, rstn, prop, msg)
`define EMTA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: design/emta_pkg.sv
// ----------------------------------------------------------------------------
// extent map package
// shared types, codes and defaults of the extent map translate/append core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package emta_pkg;

  localparam int MAX_EXTENTS_DEF = 16;

  // request codes
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_RESET  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
  localparam logic [1:0] ST_NO_SPACE   = 2'd2;
  localparam logic [1:0] ST_BEYOND_END = 2'd3;

  localparam logic [31:0] TOTAL_LIMIT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] logical_index;
    logic [31:0] fresh_block;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] target_block;
    logic [31:0] offset_in_extent;
    logic [3:0]  extent_index;
    logic        block_used;
    logic [31:0] mapped_total;
  } out_item_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } entry_t;

  // context handed to the miss/append resolver
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] logical_index;
    logic [31:0] fresh_block;
    logic [31:0] total;
    entry_t      last;
  } rsv_ctx_t;

  // resolver decision
  typedef struct packed {
    out_item_t   result;
    logic        wr_en;
    entry_t      wr_data;
    logic [31:0] total_nxt;
  } rsv_act_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RESOLVE,
    S_DONE
  } emta_state_t;

endpackage

// File: design/emta_ram.sv
// ----------------------------------------------------------------------------
// generic single-port-write ram
// one write and one read port, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module emta_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/emta_resolve.sv
// ----------------------------------------------------------------------------
// extent map miss resolver
// decides the answer and table update for a reset, a miss or an append
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module emta_resolve
  import emta_pkg::*;
#(
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1),
  localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1
) (
  input  rsv_ctx_t         ctx,
  input  logic [CNT_W-1:0] count,
  output rsv_act_t         act,
  output logic [CNT_W-1:0] count_nxt,
  output logic [IDX_W-1:0] wr_addr
);

  logic [CNT_W-1:0] last_idx;
  logic             merge;
  logic             no_room;
  logic [31:0]      ix_wide;

  always_comb begin
    last_idx = count - CNT_W'(1);
    merge    = (count != '0) && ((ctx.last.start + ctx.last.length) == ctx.fresh_block);
    no_room  = (count >= CNT_W'(MAX_EXTENTS));
    ix_wide  = merge ? 32'(last_idx) : 32'(count);

    act        = '0;
    act.result.mapped_total = ctx.total;
    act.total_nxt = ctx.total;
    count_nxt  = count;
    wr_addr    = merge ? last_idx[IDX_W-1:0] : count[IDX_W-1:0];

    if (ctx.req_type == REQ_RESET) begin
      act.total_nxt = '0;
      act.result.mapped_total = '0;
      count_nxt = '0;
    end else if (ctx.req_type != REQ_WRITE) begin
      act.result.status = ST_NOT_MAPPED;
    end else if (ctx.logical_index != ctx.total) begin
      act.result.status = ST_BEYOND_END;
    end else if (ctx.total == TOTAL_LIMIT) begin
      act.result.status = ST_NO_SPACE;
    end else if (!merge && no_room) begin
      act.result.status = ST_NO_SPACE;
    end else begin
      // append: grow the last extent or open a new one
      act.wr_en = 1'b1;
      if (merge) begin
        act.wr_data.start  = ctx.last.start;
        act.wr_data.length = ctx.last.length + 32'd1;
        act.result.offset_in_extent = ctx.last.length;
      end else begin
        act.wr_data.start  = ctx.fresh_block;
        act.wr_data.length = 32'd1;
        count_nxt = count + CNT_W'(1);
      end
      act.result.status       = ST_OK;
      act.result.target_block = ctx.fresh_block;
      act.result.extent_index = ix_wide[3:0];
      act.result.block_used   = 1'b1;
      act.total_nxt           = ctx.total + 32'd1;
      act.result.mapped_total = ctx.total + 32'd1;
    end
  end

endmodule

// File: design/extent_map_translate_append_core.sv
// ----------------------------------------------------------------------------
// extent map translate/append core
// translates logical file blocks to physical blocks, appends on write
// ----------------------------------------------------------------------------
// The extent table (start and length per extent) lives in one ram with
// registered read; the extent count and the running block total are flops.
// Requests are handled one at a time. A lookup or write-map walks the
// extents in order, one extent per cycle, subtracting lengths until the
// logical block falls inside an extent. A hit ends the walk at that extent;
// a miss runs past the last extent into the resolve/write-back step that
// decides not-mapped, beyond-end, no-space or an append. A reset request,
// like any request on an empty table, skips the walk and goes to resolve.
// The walk pace is set by the ram read port: one extent a cycle.
// A finished result sits in an output register, so the next request can be
// taken while the previous result is still stalled downstream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "extent_map_translate_append_core_macros.svh"

module extent_map_translate_append_core
  import emta_pkg::*;
#(
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  // request channel
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  // result channel
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
  localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

  emta_state_t state_r, state_nxt;

  // request context
  logic [1:0]       req_r;
  logic [31:0]      logical_r;
  logic [31:0]      fresh_r;
  logic [31:0]      rem_r;        // logical index left after the extents passed
  logic [IDX_W-1:0] idx_r;        // extent whose data is on the ram output
  entry_t           last_r;       // last extent seen by the walk

  // table summary
  logic [CNT_W-1:0] count_r;
  logic [31:0]      total_r;

  out_item_t        res_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  // ram ports
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_entry;
  logic [63:0]      rd_raw;

  // walk step
  logic [CNT_W-1:0] idx_inc;
  logic             hit;
  logic             more;
  logic [31:0]      ix_wide;
  out_item_t        hit_res;

  // resolver
  rsv_ctx_t         ctx;
  rsv_act_t         act;
  logic [CNT_W-1:0] count_nxt;
  logic [IDX_W-1:0] wr_addr;

  logic             in_xfer;
  logic             out_load;
  logic             rsv_commit;

  assign in_xfer  = in_valid && !in_stall;
  assign rd_entry = entry_t'(rd_raw);

  // next extent to fetch; in idle prefetch extent 0 for the coming request
  assign idx_inc = CNT_W'(idx_r) + CNT_W'(1);
  assign rd_addr = (state_r == S_IDLE) ? '0 : idx_inc[IDX_W-1:0];

  assign hit     = rem_r < rd_entry.length;
  assign more    = idx_inc < count_r;
  assign ix_wide = 32'(idx_r);

  always_comb begin
    hit_res                  = '0;
    hit_res.status           = ST_OK;
    hit_res.target_block     = rd_entry.start + rem_r;
    hit_res.offset_in_extent = rem_r;
    hit_res.extent_index     = ix_wide[3:0];
    hit_res.mapped_total     = total_r;
  end

  emta_ram #(
    .WIDTH (64),
    .DEPTH (MAX_EXTENTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (rsv_commit && act.wr_en),
    .wr_addr (wr_addr),
    .wr_data (act.wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  always_comb begin
    ctx.req_type      = req_r;
    ctx.logical_index = logical_r;
    ctx.fresh_block   = fresh_r;
    ctx.total         = total_r;
    ctx.last          = last_r;
  end

  emta_resolve #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_resolve (
    .ctx       (ctx),
    .count     (count_r),
    .act       (act),
    .count_nxt (count_nxt),
    .wr_addr   (wr_addr)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and control
  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    rsv_commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          // reset requests and an empty table skip the walk
          if (in_data.req_type == REQ_RESET || count_r == '0) begin
            state_nxt = S_RESOLVE;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (hit) begin
          state_nxt = S_DONE;
        end else if (!more) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        rsv_commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // request context and walk registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r     <= in_data.req_type;
      logical_r <= in_data.logical_index;
      fresh_r   <= in_data.fresh_block;
      rem_r     <= in_data.logical_index;
      idx_r     <= '0;
    end else if (state_r == S_WALK) begin
      if (hit) begin
        res_r <= hit_res;
      end else begin
        rem_r  <= rem_r - rd_entry.length;
        last_r <= rd_entry;
        if (more) begin
          idx_r <= idx_inc[IDX_W-1:0];
        end
      end
    end else if (rsv_commit) begin
      res_r <= act.result;
    end
  end

  // extent count and running total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
    end else if (rsv_commit) begin
      count_r <= count_nxt;
      total_r <= act.total_nxt;
    end
  end

  // output register, decouples the result transfer from the next request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `EMTA_ASSERT(a_count_range, clk, rst_n, count_r <= CNT_W'(MAX_EXTENTS),
               "extent count above table size")
  `EMTA_ASSERT(a_used_ok, clk, rst_n,
               !(out_valid && out_data.block_used) || out_data.status == ST_OK,
               "block used on a failed request")
  `EMTA_ASSERT(a_fail_zero, clk, rst_n,
               !(out_valid && out_data.status != ST_OK) ||
               (out_data.target_block == '0 && out_data.offset_in_extent == '0),
               "failed result carries a mapping")
  `EMTA_ASSERT_NEXT(a_append_total, clk, rst_n, rsv_commit && act.wr_en,
                    total_r == $past(total_r) + 32'd1,
                    "append did not grow the block total")

endmodule

// File: tb/sv/extent_map_translate_append_core_test.sv
// ----------------------------------------------------------------------------
// extent map translate/append core testbench
// self-checking run of lookups, write-maps with append and table resets
// ----------------------------------------------------------------------------
// A queue of requests is built up front: a short directed pass (empty table,
// wrap-around merge, write hit, spare request code, a full table, no space,
// table reset) and then random traffic in which nearly half the requests
// are appends at the next logical block, so that the table actually
// fills and merges. A driver offers the queue with random gaps; a monitor
// predicts each accepted request on its own copy of the extent table and
// checks every transfer on the result side field by field. The receiver
// stalls at random, and once holds off long enough to back the core up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module extent_map_translate_append_core_test;
  import emta_pkg::*;

  localparam int          EXTENTS    = MAX_EXTENTS_DEF;
  localparam logic [1:0]  REQ_SPARE  = 2'd3;       // unused code, acts as a lookup
  localparam int          N_RANDOM   = 700;
  localparam int          HOLD_MARK  = 300;        // long receiver hold-off starts here
  localparam int          HOLD_LEN   = 400;
  localparam int          DRAIN_MARK = 500;        // sender waits for an empty pipe here
  localparam int          TAIL       = 40;         // beyond the longest walk
  localparam int unsigned LIMIT      = 400000;

  // shadow of the extent table; one copy plans stimulus, one predicts results
  typedef struct {
    logic [31:0] start [EXTENTS];
    logic [31:0] span  [EXTENTS];
    int unsigned used;
    logic [31:0] total;
  } extent_table_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  in_item_t      pending_reqs [$];
  out_item_t     expected_results [$];
  extent_table_t plan_map;
  extent_table_t dut_map;

  int          n_sent;
  int          n_received;
  int          n_errors;
  int unsigned n_cycles;
  bit          in_fired;     // set at the edge that took a request

  extent_map_translate_append_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // walk the extents for a request and apply any append or reset to the table
  function automatic out_item_t translate(inout extent_table_t m, input in_item_t rq);
    out_item_t   r;
    logic [31:0] rest;
    logic [31:0] tail;
    logic        hit;
    int unsigned k;
    r    = '0;
    hit  = 1'b0;
    rest = rq.logical_index;
    if (rq.req_type == REQ_RESET) begin
      m.used  = 0;
      m.total = '0;
    end else begin
      for (k = 0; k < m.used; k++) begin
        if (!hit) begin
          if (rest < m.span[k]) begin
            hit                = 1'b1;
            r.target_block     = m.start[k] + rest;
            r.offset_in_extent = rest;
            r.extent_index     = 4'(k);
          end else begin
            rest = rest - m.span[k];
          end
        end
      end
      if (hit) begin
        r.status = ST_OK;
      end else if (rq.req_type != REQ_WRITE) begin
        r.status = ST_NOT_MAPPED;
      end else if (rq.logical_index != m.total) begin
        r.status = ST_BEYOND_END;
      end else if (m.total == TOTAL_LIMIT) begin
        r.status = ST_NO_SPACE;
      end else begin
        tail = (m.used > 0) ? m.start[m.used-1] + m.span[m.used-1] : '0;
        if (m.used > 0 && tail == rq.fresh_block) begin
          // fresh block directly follows the last extent: grow it
          m.span[m.used-1]   = m.span[m.used-1] + 1;
          r.offset_in_extent = m.span[m.used-1] - 1;
          r.extent_index     = 4'(m.used - 1);
          r.block_used       = 1'b1;
        end else if (m.used >= EXTENTS) begin
          r.status = ST_NO_SPACE;
        end else begin
          m.start[m.used] = rq.fresh_block;
          m.span[m.used]  = 32'd1;
          r.extent_index  = 4'(m.used);
          m.used          = m.used + 1;
          r.block_used    = 1'b1;
        end
        if (r.block_used) begin
          m.total        = m.total + 1;
          r.target_block = rq.fresh_block;
        end
      end
    end
    r.mapped_total = m.total;
    return r;
  endfunction

  // queue a request and keep the planning copy of the table in step
  task automatic queue_request(input logic [1:0] kind, input logic [31:0] lblk,
                               input logic [31:0] fresh);
    in_item_t  q;
    out_item_t ignored;
    q.req_type      = kind;
    q.logical_index = lblk;
    q.fresh_block   = fresh;
    ignored         = translate(plan_map, q);
    pending_reqs.push_back(q);
  endtask

  // random request shaped by the planned table: nearly half are appends at the end
  task automatic queue_random_request();
    logic [1:0]  kind;
    logic [31:0] lblk;
    logic [31:0] fresh;
    int unsigned pick;
    kind  = REQ_LOOKUP;
    lblk  = $urandom;
    fresh = $urandom;
    pick  = $urandom_range(0, 99);
    if (pick < 2) begin
      kind = REQ_RESET;
    end else if (pick < 50) begin
      kind = REQ_WRITE;
      lblk = plan_map.total;
      if (plan_map.used > 0 && $urandom_range(0, 99) < 55)
        fresh = plan_map.start[plan_map.used-1] + plan_map.span[plan_map.used-1];
    end else if (pick < 62) begin
      kind = REQ_WRITE;
      if (plan_map.total != 0) lblk = $urandom_range(0, plan_map.total - 1);
    end else if (pick < 68) begin
      kind = REQ_WRITE;
      if ($urandom_range(0, 1)) lblk = plan_map.total + $urandom_range(1, 8);
    end else if (pick < 88) begin
      if (plan_map.total != 0) lblk = $urandom_range(0, plan_map.total - 1);
    end else if (pick >= 95) begin
      kind = REQ_SPARE;
      if (plan_map.total != 0 && $urandom_range(0, 1))
        lblk = $urandom_range(0, plan_map.total - 1);
    end
    queue_request(kind, lblk, fresh);
  endtask

  // idle length: mostly none, sometimes a few cycles, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    int unsigned g;
    r = $urandom_range(0, 99);
    if (r < 55)      g = 0;
    else if (r < 92) g = $urandom_range(1, 3);
    else             g = $urandom_range(10, 40);
    return g;
  endfunction

  task automatic report(input string field, input logic [31:0] want,
                        input logic [31:0] got);
    $display("%0t: mismatch on %s, expected %h, got %h", $time, field, want, got);
    n_errors++;
  endtask

  task automatic check_result(input out_item_t want, input out_item_t got);
    if (got.status !== want.status)
      report("status", 32'(want.status), 32'(got.status));
    if (got.target_block !== want.target_block)
      report("target_block", want.target_block, got.target_block);
    if (got.offset_in_extent !== want.offset_in_extent)
      report("offset_in_extent", want.offset_in_extent, got.offset_in_extent);
    if (got.extent_index !== want.extent_index)
      report("extent_index", 32'(want.extent_index), 32'(got.extent_index));
    if (got.block_used !== want.block_used)
      report("block_used", 32'(want.block_used), 32'(got.block_used));
    if (got.mapped_total !== want.mapped_total)
      report("mapped_total", want.mapped_total, got.mapped_total);
  endtask

  // request driver: holds the payload while stalled, may idle between transfers
  int unsigned send_idle;
  always @(negedge clk) begin
    logic busy;
    if (rst_n) begin
      busy = in_valid && !in_fired;
      if (in_fired) begin
        in_fired = 1'b0;
        n_sent++;
        // every fourth stretch of 64 requests goes back to back
        send_idle = (((n_sent / 64) % 4) == 1) ? 0 : pick_gap();
      end
      if (!busy) begin
        if (send_idle > 0) begin
          send_idle--;
          in_valid <= 1'b0;
        end else if (n_sent == DRAIN_MARK && expected_results.size() != 0) begin
          // pause once until every outstanding result is back
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side stall: random, plus one long hold-off to fill the core
  int unsigned stall_left;
  int unsigned hold_left;
  bit          held_once;
  always @(negedge clk) begin
    int unsigned g;
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held_once && n_sent >= HOLD_MARK) begin
        held_once = 1'b1;
        hold_left = HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (((n_received / 64) % 4) == 2) begin
        out_stall <= 1'b0;
      end else begin
        g = pick_gap();
        stall_left = (g > 0) ? g - 1 : 0;
        out_stall <= (g > 0);
      end
    end
  end

  // monitor: predict on request transfers, check on result transfers
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(translate(dut_map, in_data));
        in_fired = 1'b1;
      end
      if (out_valid && !out_stall) begin
        n_received++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, out_data);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          check_result(want, out_data);
        end
      end
    end
    n_cycles++;
    if (n_cycles > LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int k;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    in_fired   = 1'b0;
    n_sent     = 0;
    n_received = 0;
    n_errors   = 0;
    n_cycles   = 0;
    send_idle  = 0;
    stall_left = 0;
    hold_left  = 0;
    held_once  = 1'b0;
    plan_map.used  = 0;
    plan_map.total = '0;
    dut_map.used   = 0;
    dut_map.total  = '0;

    // empty table: lookup misses, write-map off the end
    queue_request(REQ_LOOKUP, 32'd0, 32'd0);
    queue_request(REQ_WRITE, 32'd5, 32'h1234_5678);
    // first extent at the top block, next block wraps to zero and merges
    queue_request(REQ_WRITE, 32'd0, 32'hFFFF_FFFF);
    queue_request(REQ_WRITE, 32'd1, 32'h0000_0000);
    // write-map hit leaves the fresh block unused
    queue_request(REQ_WRITE, 32'd0, 32'hDEAD_BEEF);
    // spare request code behaves as a lookup
    queue_request(REQ_SPARE, 32'd1, 32'hFFFF_FFFF);
    queue_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // fill the remaining slots with non-contiguous extents
    for (k = 0; k < EXTENTS - 1; k++)
      queue_request(REQ_WRITE, plan_map.total, {16'(k * 3 + 7), 16'hA5A5});
    // table full and block not contiguous: no space
    queue_request(REQ_WRITE, plan_map.total, 32'h0BAD_0000);
    // last block sits in the highest extent
    queue_request(REQ_LOOKUP, plan_map.total - 1, 32'd0);
    queue_request(REQ_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    for (k = 0; k < N_RANDOM; k++)
      queue_random_request();

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (TAIL) @(negedge clk);
    if (n_errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
